### rtl/core/tkns_pkg.sv
package tkns_pkg;

  // Fixed field widths on the ports
  localparam int IN_ID_W    = 20;
  localparam int IN_DIST_W  = 24;
  localparam int OUT_RANK_W = 4;
  localparam int S_TDATA_W  = 48;  // id + distance = 44, padded to 6 bytes
  localparam int M_TDATA_W  = 48;  // rank + id + distance = 48

  // Defaults for the top-level parameters
  localparam int KEEP_COUNT_DEF = 10;
  localparam int ID_BITS_DEF    = 20;
  localparam int DIST_BITS_DEF  = 24;

  // Per-cycle control broadcast to every cell of the chain
  typedef struct packed {
    logic ins;  // insert the candidate beat
    logic clr;  // treat the list as empty before inserting
    logic rot;  // rotate the list one slot toward cell 0
  } cell_ctl_t;

  // Top-level sequencing
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } state_t;

endpackage

### rtl/core/tkns_cell.sv
module tkns_cell #(
  parameter int ID_BITS   = tkns_pkg::ID_BITS_DEF,
  parameter int DIST_BITS = tkns_pkg::DIST_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  tkns_pkg::cell_ctl_t     ctl,
  input  logic [ID_BITS-1:0]      cand_id,
  input  logic [DIST_BITS-1:0]    cand_dist,
  // left neighbor (nearer rank), already cleared if ctl.clr
  input  logic                    left_beats,
  input  logic                    left_valid,
  input  logic [ID_BITS-1:0]      left_id,
  input  logic [DIST_BITS-1:0]    left_dist,
  // right neighbor raw contents, used while rotating
  input  logic                    right_valid,
  input  logic [ID_BITS-1:0]      right_id,
  input  logic [DIST_BITS-1:0]    right_dist,
  // this slot as seen by the right neighbor during insertion
  output logic                    beats,
  output logic                    eff_valid,
  output logic [ID_BITS-1:0]      eff_id,
  output logic [DIST_BITS-1:0]    eff_dist,
  // raw contents
  output logic                    valid,
  output logic [ID_BITS-1:0]      id,
  output logic [DIST_BITS-1:0]    distance
);
  import tkns_pkg::*;

  logic                 valid_next;
  logic [ID_BITS-1:0]   id_next;
  logic [DIST_BITS-1:0] dist_next;

  // Slot contents after an optional clear
  always_comb begin
    eff_valid = valid & ~ctl.clr;
    eff_id    = ctl.clr ? '0 : id;
    eff_dist  = ctl.clr ? '1 : distance;
  end

  // Empty slots lose to every candidate; ties keep the older entry
  assign beats = ~eff_valid | (cand_dist < eff_dist);

  // Rotate from the right, shift from the left, take the candidate, or hold
  always_comb begin
    valid_next = valid;
    id_next    = id;
    dist_next  = distance;
    if (ctl.rot) begin
      valid_next = right_valid;
      id_next    = right_id;
      dist_next  = right_dist;
    end else if (ctl.ins) begin
      if (left_beats) begin
        valid_next = left_valid;
        id_next    = left_id;
        dist_next  = left_dist;
      end else if (beats) begin
        valid_next = 1'b1;
        id_next    = cand_id;
        dist_next  = cand_dist;
      end else begin
        valid_next = eff_valid;
        id_next    = eff_id;
        dist_next  = eff_dist;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= 1'b0;
      id       <= '0;
      distance <= '1;
    end else begin
      valid    <= valid_next;
      id       <= id_next;
      distance <= dist_next;
    end
  end

endmodule

### rtl/core/top_k_nearest_select.sv
// Channel   Dir  tdata (low bit first)                        tuser            tlast
// s_axis    in   candidate_id[19:0], sq_distance[43:20]       first_of_query   last_of_query
// m_axis    out  rank[3:0], result_id[23:4], result_dist[47:24] slot_valid     last_result
//
// One input beat is taken per cycle while s_axis_tready is high; every slot compares and shifts in the same cycle.
// A last-of-query beat is followed by KEEP_COUNT output beats, one per cycle when
// m_axis_tready is high; s_axis_tready stays low until the final one is taken.
// Output beats come from cell 0 while the chain rotates, so the list is intact afterward.
// Synchronous reset empties all slots at once.
module top_k_nearest_select #(
  parameter int KEEP_COUNT = tkns_pkg::KEEP_COUNT_DEF,
  parameter int ID_BITS    = tkns_pkg::ID_BITS_DEF,
  parameter int DIST_BITS  = tkns_pkg::DIST_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [tkns_pkg::S_TDATA_W-1:0] s_axis_tdata,  // candidate_id, sq_distance, pad
  input  logic [0:0]                     s_axis_tuser,  // first_of_query
  input  logic                           s_axis_tlast,  // last_of_query
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [tkns_pkg::M_TDATA_W-1:0] m_axis_tdata,  // rank, result_id, result_distance
  output logic [0:0]                     m_axis_tuser,  // slot_valid
  output logic                           m_axis_tlast   // last_result
);
  import tkns_pkg::*;

  localparam int CNT_W     = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;
  localparam int SAT_SHIFT = (DIST_BITS >= IN_DIST_W) ? 0 : IN_DIST_W - DIST_BITS;
  localparam logic [IN_DIST_W-1:0] SAT_LIM = {IN_DIST_W{1'b1}} >> SAT_SHIFT;
  localparam logic [CNT_W-1:0]     CNT_LAST = CNT_W'(KEEP_COUNT - 1);

  state_t            state, state_next;
  logic [CNT_W-1:0]  rank_cnt;
  logic              in_beat, out_beat, out_final;
  cell_ctl_t         ctl;

  logic [IN_ID_W-1:0]   in_id;
  logic [IN_DIST_W-1:0] in_dist;
  logic [ID_BITS-1:0]   cand_id;
  logic [DIST_BITS-1:0] cand_dist;

  logic [KEEP_COUNT-1:0] beats, eff_valid, valid_vec;
  logic [ID_BITS-1:0]    eff_id [KEEP_COUNT];
  logic [DIST_BITS-1:0]  eff_dist [KEEP_COUNT];
  logic [ID_BITS-1:0]    id_q [KEEP_COUNT];
  logic [DIST_BITS-1:0]  dist_q [KEEP_COUNT];

  // Unpack and fit the candidate to the slot widths
  assign in_id     = s_axis_tdata[IN_ID_W-1:0];
  assign in_dist   = s_axis_tdata[IN_ID_W +: IN_DIST_W];
  assign cand_id   = ID_BITS'(in_id);
  assign cand_dist = (in_dist > SAT_LIM) ? '1 : DIST_BITS'(in_dist);

  assign in_beat   = s_axis_tvalid & s_axis_tready;
  assign out_beat  = m_axis_tvalid & m_axis_tready;
  assign out_final = out_beat & (rank_cnt == CNT_LAST);

  always_comb begin
    ctl.ins = in_beat;
    ctl.clr = in_beat & s_axis_tuser[0];
    ctl.rot = out_beat;
  end

  // Cell chain, cell 0 holds the nearest entry
  for (genvar i = 0; i < KEEP_COUNT; i++) begin : g_cell
    localparam int NXT = (i + 1) % KEEP_COUNT;
    logic                 l_beats, l_valid;
    logic [ID_BITS-1:0]   l_id;
    logic [DIST_BITS-1:0] l_dist;

    if (i == 0) begin : g_head
      assign l_beats = 1'b0;
      assign l_valid = 1'b0;
      assign l_id    = cand_id;
      assign l_dist  = cand_dist;
    end else begin : g_body
      assign l_beats = beats[i-1];
      assign l_valid = eff_valid[i-1];
      assign l_id    = eff_id[i-1];
      assign l_dist  = eff_dist[i-1];
    end

    tkns_cell #(
      .ID_BITS   (ID_BITS),
      .DIST_BITS (DIST_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .cand_id     (cand_id),
      .cand_dist   (cand_dist),
      .left_beats  (l_beats),
      .left_valid  (l_valid),
      .left_id     (l_id),
      .left_dist   (l_dist),
      .right_valid (valid_vec[NXT]),
      .right_id    (id_q[NXT]),
      .right_dist  (dist_q[NXT]),
      .beats       (beats[i]),
      .eff_valid   (eff_valid[i]),
      .eff_id      (eff_id[i]),
      .eff_dist    (eff_dist[i]),
      .valid       (valid_vec[i]),
      .id          (id_q[i]),
      .distance    (dist_q[i])
    );
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_beat && s_axis_tlast) state_next = ST_EMIT;
      ST_EMIT: if (out_final) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    case (state)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_EMIT: m_axis_tvalid = 1'b1;
      default: s_axis_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rank_cnt <= '0;
    end else begin
      state <= state_next;
      if (out_beat) rank_cnt <= out_final ? '0 : rank_cnt + CNT_W'(1);
    end
  end

  // Result beat straight from cell 0
  assign m_axis_tdata = {IN_DIST_W'(dist_q[0]), IN_ID_W'(id_q[0]), OUT_RANK_W'(rank_cnt)};
  assign m_axis_tuser = valid_vec[0];
  assign m_axis_tlast = (rank_cnt == CNT_LAST);

  // Input and output sides never open together
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input and output open in the same cycle");

  // A last-of-query beat starts emission at rank 0
  a_emit_start: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> (m_axis_tvalid && rank_cnt == '0))
    else $error("emission did not start at rank 0");

  // Filled slots form a prefix of the chain from cell 0 whenever the block is in ST_IDLE
  a_prefix: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> ((valid_vec & (valid_vec + KEEP_COUNT'(1))) == '0))
    else $error("filled slots are not contiguous from cell 0");

  // The final result beat returns to accepting candidates
  a_emit_end: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("input not reopened after the last result beat");

endmodule

### tb/sv/top_k_nearest_select_check.sv
`timescale 1ns / 100ps

module top_k_nearest_select_check (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [tkns_pkg::S_TDATA_W-1:0] s_axis_tdata,  // candidate_id, sq_distance, pad
  input  logic [0:0]                     s_axis_tuser,  // first_of_query
  input  logic                           s_axis_tlast,  // last_of_query
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [tkns_pkg::M_TDATA_W-1:0] m_axis_tdata,  // rank, result_id, result_distance
  input  logic [0:0]                     m_axis_tuser,  // slot_valid
  input  logic                           m_axis_tlast,  // last_result
  output int                             fail_count,
  output int                             pending,
  output int                             beats_checked
);
  import tkns_pkg::*;

  localparam int KEEP = KEEP_COUNT_DEF;
  localparam int REPORT_MAX = 10;

  typedef struct {
    logic [OUT_RANK_W-1:0] rank;
    logic [IN_ID_W-1:0]    id;
    logic [IN_DIST_W-1:0]  distance;
    logic                  filled;
    logic                  last;
  } ranked_beat_t;

  // Shadow copy of the kept list, ascending by distance
  logic [IN_DIST_W-1:0] kept_dist [KEEP];
  logic [IN_ID_W-1:0]   kept_id   [KEEP];
  logic                 kept_vld  [KEEP];

  ranked_beat_t ranked_q [$];

  initial begin
    fail_count    = 0;
    pending       = 0;
    beats_checked = 0;
  end

  function automatic void empty_list();
    for (int i = 0; i < KEEP; i++) begin
      kept_dist[i] = '1;
      kept_id[i]   = '0;
      kept_vld[i]  = 1'b0;
    end
  endfunction

  // Insertion into the sorted list; an empty slot loses to anything,
  // a tie keeps the older entry in front
  function automatic void merge_candidate(input logic [IN_ID_W-1:0] id,
                                          input logic [IN_DIST_W-1:0] cand_dist);
    int p;
    p = KEEP - 1;
    if (kept_vld[p] && !(cand_dist < kept_dist[p])) return;
    while (p > 0 && (!kept_vld[p-1] || cand_dist < kept_dist[p-1])) begin
      kept_dist[p] = kept_dist[p-1];
      kept_id[p]   = kept_id[p-1];
      kept_vld[p]  = kept_vld[p-1];
      p--;
    end
    kept_dist[p] = cand_dist;
    kept_id[p]   = id;
    kept_vld[p]  = 1'b1;
  endfunction

  function automatic void push_ranking();
    ranked_beat_t b;
    for (int k = 0; k < KEEP; k++) begin
      b.rank     = OUT_RANK_W'(k);
      b.id       = kept_id[k];
      b.distance = kept_dist[k];
      b.filled   = kept_vld[k];
      b.last     = (k == KEEP - 1);
      ranked_q.push_back(b);
    end
  endfunction

  always @(posedge clk) begin : watch
    ranked_beat_t want;
    ranked_beat_t got;
    if (rst) begin
      empty_list();
      ranked_q.delete();
    end else begin
      // output side: compare against the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        got.rank     = m_axis_tdata[OUT_RANK_W-1:0];
        got.id       = m_axis_tdata[OUT_RANK_W +: IN_ID_W];
        got.distance = m_axis_tdata[OUT_RANK_W+IN_ID_W +: IN_DIST_W];
        got.filled   = m_axis_tuser[0];
        got.last     = m_axis_tlast;
        beats_checked++;
        if (ranked_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("[%0t] unexpected result beat: rank %0d id %h dist %h valid %b last %b",
                     $realtime, got.rank, got.id, got.distance, got.filled, got.last);
        end else begin
          want = ranked_q.pop_front();
          if (got.rank !== want.rank || got.id !== want.id ||
              got.distance !== want.distance ||
              got.filled !== want.filled || got.last !== want.last) begin
            fail_count++;
            if (fail_count <= REPORT_MAX) begin
              $display("[%0t] result mismatch", $realtime);
              $display("  expected: rank %0d id %h dist %h valid %b last %b",
                       want.rank, want.id, want.distance, want.filled, want.last);
              $display("  actual:   rank %0d id %h dist %h valid %b last %b",
                       got.rank, got.id, got.distance, got.filled, got.last);
            end
          end
        end
      end
      // input side: update the shadow list
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser[0]) empty_list();
        merge_candidate(s_axis_tdata[IN_ID_W-1:0], s_axis_tdata[IN_ID_W +: IN_DIST_W]);
        if (s_axis_tlast) push_ranking();
      end
    end
    pending = ranked_q.size();
  end

endmodule

### tb/sv/top_k_nearest_select_test.sv
`timescale 1ns / 100ps

module top_k_nearest_select_test;
  import tkns_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_ITEMS = 84;
  localparam logic [IN_DIST_W-1:0] DIST_EMPTY = '1;
  localparam logic [IN_DIST_W-1:0] DIRECTED_DIST [12] = '{
    24'd500, 24'd300, 24'd700, 24'd0, 24'd300, 24'd900,
    24'd50, 24'hFFFFFF, 24'd800, 24'd600, 24'd400, 24'd800
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [0:0]           s_axis_tuser = '0;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [0:0]           m_axis_tuser;
  logic                 m_axis_tlast;

  int fail_count;
  int pending;
  int beats_checked;
  int cand_sent = 0;
  int queries_sent = 0;
  int cycles = 0;
  bit gaps_on = 1'b1;

  top_k_nearest_select dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  top_k_nearest_select_check check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count    (fail_count),
    .pending       (pending),
    .beats_checked (beats_checked)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Watchdog expired after %0d cycles, %0d beats still due", cycles, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side backpressure
  initial begin
    forever begin
      @(negedge clk);
      m_axis_tready = !gaps_on || ($urandom_range(99) >= 21);
    end
  end

  // One candidate beat; tvalid stays high into the next call
  task automatic offer(input logic [IN_ID_W-1:0] id, input logic [IN_DIST_W-1:0] distance,
                       input bit first, input bit last);
    while (gaps_on && $urandom_range(99) < 21) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {{(S_TDATA_W-IN_ID_W-IN_DIST_W){1'b0}}, distance, id};
    s_axis_tuser  = first;
    s_axis_tlast  = last;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    cand_sent++;
    if (last) queries_sent++;
  endtask

  // Hold the sender until every predicted beat has come out
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Mix of tie-prone, mid, full-range and extreme distances
  function automatic logic [IN_DIST_W-1:0] pick_distance();
    case ($urandom_range(3))
      0: return IN_DIST_W'($urandom_range(0, 15));
      1: return IN_DIST_W'($urandom_range(0, 4095));
      2: return $urandom_range(1) ? DIST_EMPTY : '0;
      default: return IN_DIST_W'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int idx;
    int len;
    bit first;
    bit last;
    bit broken;
    bit paused;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // both flags on one beat; an all-ones distance still fills an empty slot
    offer('1, DIST_EMPTY, 1'b1, 1'b1);
    // overfilled query with ties and both distance extremes
    for (int k = 0; k < 12; k++)
      offer((k == 3) ? '0 : IN_ID_W'(20'hA5A5A ^ k), DIRECTED_DIST[k], k == 0, k == 11);
    // list survives the emit when no clear comes
    offer(20'h5A5A5, 24'd1, 1'b0, 1'b1);
    // fresh query, tie at zero: the earlier id keeps rank 0
    offer(20'h00002, 24'd0, 1'b1, 1'b0);
    offer('1, 24'd0, 1'b0, 1'b1);
    drain();

    // random queries, mostly well formed, some with scrambled flags
    idx = 0;
    paused = 1'b0;
    while (idx < RANDOM_ITEMS) begin
      len = $urandom_range(1, 14);
      broken = ($urandom_range(9) == 0);
      for (int k = 0; k < len; k++) begin
        gaps_on = !(idx >= 40 && idx < 75);
        first = (k == 0);
        last = (k == len - 1);
        if (broken) begin
          first = $urandom_range(1);
          last = ($urandom_range(3) == 0);
        end
        offer(IN_ID_W'($urandom), pick_distance(), first, last);
        idx++;
      end
      if (idx > 60 && !paused) begin
        drain();
        paused = 1'b1;
      end
    end
    gaps_on = 1'b1;
    drain();
    repeat (KEEP_COUNT_DEF + 8) @(negedge clk);

    $display("Offered %0d candidates in %0d emitted queries, incl. ties, extremes and flag mixes",
             cand_sent, queries_sent);
    $display("Compared %0d ranked beats under random source gaps and sink stalls", beats_checked);
    if (fail_count == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

### files.f
rtl/core/tkns_pkg.sv
rtl/core/tkns_cell.sv
rtl/core/top_k_nearest_select.sv
tb/sv/top_k_nearest_select_check.sv
tb/sv/top_k_nearest_select_test.sv
